@@ design/tvht_pkg.sv @@
package tvht_pkg;

  // Input item of one transfer on the input channel.
  typedef struct packed {
    logic               operation;
    logic [3:0]         entry_index;
    logic               entry_enable;
    logic [7:0]         entry_window;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic signed [31:0] box_depth;
    logic               box_mode;
    logic [15:0]        query_x;
    logic [15:0]        query_y;
  } in_item_t;

  // Result item of one transfer on the output channel.
  typedef struct packed {
    logic               hit;
    logic [3:0]         hit_index;
    logic [31:0]        frac_x;
    logic [31:0]        frac_y;
    logic signed [31:0] inner_x;
    logic signed [31:0] inner_y;
  } out_item_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  localparam logic [15:0] WIDTH_RESET  = 16'd1920;
  localparam logic [15:0] HEIGHT_RESET = 16'd1080;

  // Width of the dividends and divisors handled by the shared divider.
  localparam int DIV_W = 64;

  // Saturation limit of a Q16.16 ratio.
  localparam logic [DIV_W-1:0] RATIO_MAX = DIV_W'(32'h7FFF_FFFF);

  // Slot record kept in the table memory.
  typedef struct packed {
    logic               valid;
    logic [7:0]         owner;
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic [30:0]        width;
    logic [30:0]        height;
    logic signed [31:0] depth;
    logic               mode;
  } slot_t;

endpackage

@@ design/topmost_viewport_hit_test_unit.sv @@
// Write item: accepted in any idle cycle, stored in the slot memory, no result.
// Query item: a read (ST_SCAN) and a check of every slot (ST_CHECK), then on a hit four bit-serial
// divisions (ST_DIV, ST_DSTEP) on one shared divider. The result waits in ST_OUT until it is
// transferred, and the next item is taken only after that, back in ST_IDLE, so no new item is
// taken before the last query is through.
// Synchronous active-high reset clears control state, valid marks and configuration registers.
module topmost_viewport_hit_test_unit
  import tvht_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int SW = $clog2(DIV_W + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DSTEP = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Configuration registers.
  logic [15:0] window_width;
  logic [15:0] window_height;
  logic [7:0]  active_window;
  logic        cfg_write;
  logic [1:0]  cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_reg   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
      active_window <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_reg)
        REG_WIDTH:  window_width  <= pwdata[15:0];
        REG_HEIGHT: window_height <= pwdata[15:0];
        REG_WINDOW: active_window <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_WIDTH:  prdata = {16'd0, window_width};
      REG_HEIGHT: prdata = {16'd0, window_height};
      REG_WINDOW: prdata = {24'd0, active_window};
      default:    prdata = 32'd0;
    endcase
  end

  // Slot memory with valid marks in flip-flops.
  slot_t                  slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  slot_valid;
  slot_t                  rd_slot;
  logic                   rd_valid;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;
  slot_t                  wr_slot;

  assign wr_en = in_valid && in_ready && (in_data.operation == OP_WRITE)
                 && ({28'd0, in_data.entry_index} < 32'(SLOT_COUNT));

  always_comb begin
    wr_slot        = '0;
    wr_slot.valid  = in_data.entry_enable;
    wr_slot.owner  = in_data.entry_window;
    wr_slot.left   = in_data.box_left;
    wr_slot.top    = in_data.box_top;
    wr_slot.width  = in_data.box_width;
    wr_slot.height = in_data.box_height;
    wr_slot.depth  = in_data.box_depth;
    wr_slot.mode   = in_data.box_mode;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[IW'(in_data.entry_index)] <= wr_slot;
    end
    rd_slot <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid[IW'(in_data.entry_index)] <= in_data.entry_enable;
      end
      rd_valid <= slot_valid[rd_addr];
    end
  end

  // Control and query state.
  state_t        state;
  logic [CW-1:0] scan_cnt;
  logic [CW-1:0] chk_cnt;
  logic [15:0]   qx;
  logic [15:0]   qy;
  logic [15:0]   w_eff;
  logic [15:0]   h_eff;

  assign w_eff   = (window_width == 16'd0) ? 16'd1 : window_width;
  assign h_eff   = (window_height == 16'd0) ? 16'd1 : window_height;
  assign rd_addr = IW'(scan_cnt);
  assign in_ready = (state == ST_IDLE);

  // Geometry of the slot read last cycle in pixel units, scaled by the window size when mode is set.
  logic signed [48:0] sx;
  logic signed [48:0] sy;
  logic signed [48:0] ex;
  logic signed [48:0] ey;
  logic signed [48:0] pxq;
  logic signed [48:0] pyq;
  logic               cand;
  logic               in_box;

  always_comb begin
    if (rd_slot.mode) begin
      sx = 49'(rd_slot.left * $signed({1'b0, w_eff}));
      sy = 49'(rd_slot.top * $signed({1'b0, h_eff}));
      ex = $signed(49'(rd_slot.width * w_eff));
      ey = $signed(49'(rd_slot.height * h_eff));
    end else begin
      sx = 49'(rd_slot.left);
      sy = 49'(rd_slot.top);
      ex = $signed({18'd0, rd_slot.width});
      ey = $signed({18'd0, rd_slot.height});
    end
    pxq    = $signed({17'd0, qx, 16'd0});
    pyq    = $signed({17'd0, qy, 16'd0});
    cand   = rd_valid && (rd_slot.owner == active_window);
    in_box = (pxq >= sx) && (pyq >= sy) && (pxq < sx + ex) && (pyq < sy + ey);
  end

  // Best hit so far.
  logic               found;
  logic [3:0]         best_idx;
  logic signed [31:0] best_depth;
  logic [DIV_W-1:0]   best_nx;
  logic [DIV_W-1:0]   best_ny;
  logic [DIV_W-1:0]   best_ex;
  logic [DIV_W-1:0]   best_ey;

  // Shared restoring divider: quotient of num<<16 by den, one bit a cycle.
  logic [1:0]       div_sel;
  logic [SW-1:0]    div_cnt;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W:0]   div_trial;
  logic [DIV_W-1:0] num_sel;
  logic [DIV_W-1:0] den_sel;
  logic [DIV_W-1:0] div_res;

  always_comb begin
    case (div_sel)
      2'd0: begin
        num_sel = DIV_W'({qx, 16'd0});
        den_sel = DIV_W'(w_eff);
      end
      2'd1: begin
        num_sel = DIV_W'({qy, 16'd0});
        den_sel = DIV_W'(h_eff);
      end
      2'd2: begin
        num_sel = best_nx << 16;
        den_sel = best_ex;
      end
      default: begin
        num_sel = best_ny << 16;
        den_sel = best_ey;
      end
    endcase
    div_trial = {div_rem, div_quo[DIV_W-1]} - {1'b0, div_den};
    if (div_sel[1] && div_quo > RATIO_MAX) begin
      div_res = RATIO_MAX;
    end else begin
      div_res = div_quo;
    end
  end

  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
      chk_cnt   <= '0;
      found     <= 1'b0;
      div_sel   <= 2'd0;
      div_cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_data.operation == OP_QUERY) begin
            qx       <= in_data.query_x;
            qy       <= in_data.query_y;
            found    <= 1'b0;
            scan_cnt <= '0;
            chk_cnt  <= '0;
            res      <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue the first read; later reads overlap the checks.
          scan_cnt <= scan_cnt + 1'b1;
          state    <= ST_CHECK;
        end
        ST_CHECK: begin
          if (scan_cnt < CW'(SLOT_COUNT)) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (cand && !(found && best_depth >= rd_slot.depth) && in_box) begin
            found      <= 1'b1;
            best_idx   <= 4'(chk_cnt);
            best_depth <= rd_slot.depth;
            best_nx    <= DIV_W'(pxq - sx);
            best_ny    <= DIV_W'(pyq - sy);
            best_ex    <= DIV_W'(ex);
            best_ey    <= DIV_W'(ey);
          end
          chk_cnt <= chk_cnt + 1'b1;
          if (chk_cnt == CW'(SLOT_COUNT - 1)) begin
            div_sel <= 2'd0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!found) begin
            res       <= '0;
            out_valid <= 1'b1;
            state     <= ST_OUT;
          end else begin
            div_rem <= '0;
            div_quo <= num_sel;
            div_den <= den_sel;
            div_cnt <= '0;
            state   <= ST_DSTEP;
          end
        end
        ST_DSTEP: begin
          if (div_trial[DIV_W]) begin
            div_rem <= {div_rem[DIV_W-2:0], div_quo[DIV_W-1]};
            div_quo <= {div_quo[DIV_W-2:0], 1'b0};
          end else begin
            div_rem <= div_trial[DIV_W-1:0];
            div_quo <= {div_quo[DIV_W-2:0], 1'b1};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == SW'(DIV_W)) begin
            case (div_sel)
              2'd0: res.frac_x  <= div_res[31:0];
              2'd1: res.frac_y  <= div_res[31:0];
              2'd2: res.inner_x <= div_res[31:0];
              default: res.inner_y <= div_res[31:0];
            endcase
            if (div_sel == 2'd3) begin
              res.hit       <= 1'b1;
              res.hit_index <= best_idx;
              out_valid     <= 1'b1;
              state         <= ST_OUT;
            end else begin
              div_sel <= div_sel + 2'd1;
              state   <= ST_DIV;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The last step latches the result and its own shift is unused, so the counter runs one past.
  always_comb begin
    out_data = res;
  end

endmodule
